### rtl/ptw_pkg.sv
// Package for the page table walker: store geometry, descriptor codes,
// the queued transaction type and per-level index and offset helpers.
// Depends on nothing; the top level, front end, back end and testbench import it.
package ptw_pkg;

  // Store geometry and walk depth.
  localparam int STORE_WORDS = 4096;
  localparam int LEVELS      = 4;
  localparam int WORD_W      = $clog2(STORE_WORDS);

  // Field widths.
  localparam int ADDR_W     = 48;
  localparam int DESC_W     = 64;
  localparam int WIDX_W     = 12;
  localparam int GRANULE_W  = 12;
  localparam int TIDX_W     = 9;
  localparam int BASE_W     = ADDR_W - GRANULE_W;
  localparam int FULLWORD_W = BASE_W + TIDX_W;

  // Levels: the walk starts deeper when fewer levels are configured.
  localparam logic [1:0] START_LEVEL = 2'(4 - LEVELS);
  localparam logic [1:0] LAST_LEVEL  = 2'd3;

  // Input queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Transaction kinds.
  localparam logic KIND_WRITE     = 1'b0;
  localparam logic KIND_TRANSLATE = 1'b1;

  // Descriptor type codes (bits 1:0).
  localparam logic [1:0] DTYPE_INVALID0 = 2'd0;
  localparam logic [1:0] DTYPE_BLOCK    = 2'd1;
  localparam logic [1:0] DTYPE_INVALID2 = 2'd2;
  localparam logic [1:0] DTYPE_TABLE    = 2'd3;

  // One queued input transaction.
  typedef struct packed {
    logic              kind;
    logic [WIDX_W-1:0] word_index;
    logic [DESC_W-1:0] descriptor;
    logic [ADDR_W-1:0] vaddr;
  } ptw_item_t;

  // Table index taken from the virtual address at a given level.
  function automatic logic [TIDX_W-1:0] va_index(input logic [ADDR_W-1:0] va,
                                                 input logic [1:0] level);
    logic [TIDX_W-1:0] idx;
    case (level)
      2'd0:    idx = va[39 +: TIDX_W];
      2'd1:    idx = va[30 +: TIDX_W];
      2'd2:    idx = va[21 +: TIDX_W];
      default: idx = va[12 +: TIDX_W];
    endcase
    return idx;
  endfunction

  // Mask of the virtual address bits kept as page or block offset.
  function automatic logic [ADDR_W-1:0] offset_mask(input logic [1:0] level);
    logic [ADDR_W-1:0] m;
    case (level)
      2'd0:    m = {9'h000, {39{1'b1}}};
      2'd1:    m = {18'h00000, {30{1'b1}}};
      2'd2:    m = {27'h0000000, {21{1'b1}}};
      default: m = {36'h000000000, {12{1'b1}}};
    endcase
    return m;
  endfunction

endpackage

### rtl/page_table_walker_top.sv
// Top level of the page table walker: front queue plus walking back end.
// Depends on ptw_pkg, ptw_front, ptw_back and ptw_ram.
//
// Four-level, 4 KB granule table walker over a 4096-word descriptor RAM.
// Transactions enter a two-entry queue and are executed strictly in order.
// In the back end a write transaction is a single RAM write. A translate
// transaction issues the first descriptor read when popped and then one
// more read per next-table descriptor above the last level, as each needs the
// previous descriptor from the single RAM read port. A translation that has
// finished waits in the back end while the result register is still full.
// The descriptor RAM is not cleared; reading a never-written word is not
// allowed. Write root_table_base only while the block is idle.
module page_table_walker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [11:0] in_word_index,
  input  logic [63:0] in_descriptor,
  input  logic [47:0] in_vaddr,
  output logic        empty,
  input  logic        pop,
  output logic [47:0] out_paddr,
  output logic        out_fault,
  output logic [1:0]  out_end_level
);
  import ptw_pkg::*;

  logic      q_valid;
  logic      q_pop;
  ptw_item_t q_item;

  ptw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_word_index(in_word_index),
    .in_descriptor(in_descriptor),
    .in_vaddr     (in_vaddr),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  ptw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_paddr    (out_paddr),
    .out_fault    (out_fault),
    .out_end_level(out_end_level)
  );

  // A faulting result always carries a zero address.
  a_fault_zero_pa: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_fault) |-> (out_paddr == '0))
    else $error("fault result with nonzero physical address");

  // Reset leaves the result register empty and the input queue not full.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // A waiting result is not dropped before it is taken.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result lost without pop");

  // The back end only takes from the queue when it holds a transaction.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

### rtl/ptw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; the read data holds while no read is issued.
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/ptw_front.sv
// Front end of the page table walker: accepts input transactions, keeps
// every field of each, and queues them in order for the back end.
// Depends on ptw_pkg.
module ptw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_kind,
  input  logic [11:0]         in_word_index,
  input  logic [63:0]         in_descriptor,
  input  logic [47:0]         in_vaddr,
  output logic                q_valid,
  output ptw_pkg::ptw_item_t  q_item,
  input  logic                q_pop
);
  import ptw_pkg::*;

  ptw_item_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;
  ptw_item_t         new_item;

  // Classify the transaction: only the low bit of kind matters.
  always_comb begin
    new_item.kind       = in_kind ? KIND_TRANSLATE : KIND_WRITE;
    new_item.word_index = in_word_index;
    new_item.descriptor = in_descriptor;
    new_item.vaddr      = in_vaddr;
  end

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Queue control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### rtl/ptw_back.sv
// Back end of the page table walker: executes queued transactions against
// the descriptor RAM, walks the tables and holds the result register.
// Depends on ptw_pkg and ptw_ram.
module ptw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [47:0]        cfg_wr_data,
  input  logic               q_valid,
  input  ptw_pkg::ptw_item_t q_item,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [47:0]        out_paddr,
  output logic               out_fault,
  output logic [1:0]         out_end_level
);
  import ptw_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] root_r;
  logic [ADDR_W-1:0] va_r, va_nxt;
  logic [1:0]        level_r, level_nxt;
  logic              in_range_r, in_range_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_pa_r, out_pa_nxt;
  logic              out_fault_r, out_fault_nxt;
  logic [1:0]        out_level_r, out_level_nxt;

  logic                  ram_we, ram_re;
  logic [WORD_W-1:0]     ram_waddr, ram_raddr;
  logic [DESC_W-1:0]     ram_rdata;
  logic [DESC_W-1:0]     desc;
  logic [1:0]            dtype;
  logic [BASE_W-1:0]     rd_base;
  logic [ADDR_W-1:0]     rd_va;
  logic [1:0]            rd_level;
  logic [FULLWORD_W-1:0] rd_word;
  logic                  out_free;
  logic [ADDR_W-1:0]     omask;

  ptw_ram #(
    .WIDTH(DESC_W),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(q_item.descriptor),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // A descriptor fetched from beyond the store reads as zero.
  assign desc     = in_range_r ? ram_rdata : '0;
  assign dtype    = desc[1:0];
  assign omask    = offset_mask(level_r);
  assign out_free = !out_valid_r || pop;

  // Descriptor word address for the read being issued.
  assign rd_word   = {rd_base, va_index(rd_va, rd_level)};
  assign ram_raddr = rd_word[WORD_W-1:0];
  assign ram_waddr = WORD_W'(q_item.word_index);

  // Walk sequencer: one descriptor read per level, next read issued as
  // soon as the current descriptor arrives.
  always_comb begin
    state_nxt     = state_r;
    va_nxt        = va_r;
    level_nxt     = level_r;
    in_range_nxt  = in_range_r;
    out_valid_nxt = out_valid_r && !pop;
    out_pa_nxt    = out_pa_r;
    out_fault_nxt = out_fault_r;
    out_level_nxt = out_level_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rd_base       = root_r[ADDR_W-1:GRANULE_W];
    rd_va         = q_item.vaddr;
    rd_level      = START_LEVEL;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.kind == KIND_WRITE) begin
            ram_we = (32'(q_item.word_index) < 32'(STORE_WORDS));
          end else begin
            ram_re       = 1'b1;
            va_nxt       = q_item.vaddr;
            level_nxt    = START_LEVEL;
            in_range_nxt = (rd_word < FULLWORD_W'(STORE_WORDS));
            state_nxt    = S_WALK;
          end
        end
      end
      S_WALK: begin
        rd_base  = desc[ADDR_W-1:GRANULE_W];
        rd_va    = va_r;
        rd_level = level_r + 1'b1;
        if (dtype == DTYPE_TABLE && level_r != LAST_LEVEL) begin
          ram_re       = 1'b1;
          level_nxt    = rd_level;
          in_range_nxt = (rd_word < FULLWORD_W'(STORE_WORDS));
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = level_r;
          if (dtype == DTYPE_TABLE || dtype == DTYPE_BLOCK) begin
            out_pa_nxt    = ({desc[ADDR_W-1:GRANULE_W], {GRANULE_W{1'b0}}} & ~omask)
                            | (va_r & omask);
            out_fault_nxt = 1'b0;
          end else begin
            out_pa_nxt    = '0;
            out_fault_nxt = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, walk context and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      root_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        root_r <= cfg_wr_data;
      end
    end
    va_r        <= va_nxt;
    level_r     <= level_nxt;
    in_range_r  <= in_range_nxt;
    out_pa_r    <= out_pa_nxt;
    out_fault_r <= out_fault_nxt;
    out_level_r <= out_level_nxt;
  end

  assign empty         = !out_valid_r;
  assign out_paddr     = out_pa_r;
  assign out_fault     = out_fault_r;
  assign out_end_level = out_level_r;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for page_table_walker_top: descriptor writes and translations, directed and
// random, checked against a table walk modeled in the bench. Depends on ptw_pkg and the walker.
module testbench;
  import ptw_pkg::*;

  localparam int WATCHDOG_CYCLES = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int ITEM_TARGET     = 2000;
  localparam int FINAL_ITEMS     = 200;
  localparam int PHASE_ITEMS     = 300;

  typedef struct packed {
    logic [ADDR_W-1:0] paddr;
    logic              fault;
    logic [1:0]        end_level;
  } translation_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_wr_en     = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data   = '0;
  logic              push          = 1'b0;
  logic              full;
  logic              in_kind       = KIND_WRITE;
  logic [WIDX_W-1:0] in_word_index = '0;
  logic [DESC_W-1:0] in_descriptor = '0;
  logic [ADDR_W-1:0] in_vaddr      = '0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [ADDR_W-1:0] out_paddr;
  logic              out_fault;
  logic [1:0]        out_end_level;

  // Bench copy of the descriptor store, which words hold data, and the root register.
  logic [DESC_W-1:0] desc_mirror [STORE_WORDS];
  bit                desc_written [STORE_WORDS];
  logic [ADDR_W-1:0] root_base = '0;

  translation_t      pending_translations [$];
  int                items_sent       = 0;
  int                mismatches       = 0;
  int                quiet_cycles     = 0;
  int                rx_idle_left     = 0;
  int                hold_left        = 0;
  bit                idling_on        = 1'b1;
  bit                hold_off_request = 1'b0;
  logic [ADDR_W-1:0] last_va          = '0;

  page_table_walker_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .push         (push),
    .full         (full),
    .in_kind      (in_kind),
    .in_word_index(in_word_index),
    .in_descriptor(in_descriptor),
    .in_vaddr     (in_vaddr),
    .empty        (empty),
    .pop          (pop),
    .out_paddr    (out_paddr),
    .out_fault    (out_fault),
    .out_end_level(out_end_level)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Ends the run when no transaction moves on either side for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Compares each accepted result with the oldest pending translation, then decides pop.
  always @(posedge clk) begin
    translation_t want;
    if (rst_n && pop && !empty) begin
      if (pending_translations.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: pa=%h fault=%b level=%0d",
                   out_paddr, out_fault, out_end_level);
        end
      end else begin
        want = pending_translations.pop_front();
        if (want.paddr !== out_paddr || want.fault !== out_fault ||
            want.end_level !== out_end_level) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected pa=%h fault=%b level=%0d",
                     want.paddr, want.fault, want.end_level);
            $display("          got pa=%h fault=%b level=%0d",
                     out_paddr, out_fault, out_end_level);
          end
        end
      end
    end
    // The long hold-off is counted here; short random stalls come in bursts.
    if (hold_off_request) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (rx_idle_left > 0) begin
      rx_idle_left--;
      pop <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_idle_left = $urandom_range(1, 3) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Walks the bench copy of the tables. Sets missing to the first in-range word that the
  // walk would read before it was ever written, or to -1 when the walk is fully defined.
  function automatic translation_t walk_tables(input logic [ADDR_W-1:0] va,
                                               output int missing);
    translation_t      r;
    logic [ADDR_W-1:0] table_addr;
    logic [ADDR_W-1:0] entry_addr;
    logic [ADDR_W-1:0] keep_mask;
    logic [DESC_W-1:0] desc;
    logic [TIDX_W-1:0] idx;
    int                lv;
    int                shift;
    bit                done;
    r = '0;
    r.end_level = LAST_LEVEL;
    missing = -1;
    done = 1'b0;
    table_addr = {root_base[ADDR_W-1:GRANULE_W], {GRANULE_W{1'b0}}};
    for (lv = START_LEVEL; lv <= LAST_LEVEL && !done; lv++) begin
      shift = GRANULE_W + TIDX_W * (3 - lv);
      idx = va[shift +: TIDX_W];
      entry_addr = table_addr + {idx, 3'b000};
      r.end_level = 2'(lv);
      // Descriptors beyond the store read as zero, which is invalid.
      if ((entry_addr >> 3) >= STORE_WORDS) begin
        desc = '0;
      end else begin
        if (!desc_written[entry_addr >> 3]) begin
          missing = int'(entry_addr >> 3);
          return r;
        end
        desc = desc_mirror[entry_addr >> 3];
      end
      if (desc[1:0] == DTYPE_TABLE && lv < LAST_LEVEL) begin
        table_addr = {desc[ADDR_W-1:GRANULE_W], {GRANULE_W{1'b0}}};
      end else if (desc[1:0] == DTYPE_TABLE || desc[1:0] == DTYPE_BLOCK) begin
        keep_mask = (48'd1 << shift) - 48'd1;
        r.paddr = ({desc[ADDR_W-1:GRANULE_W], {GRANULE_W{1'b0}}} & ~keep_mask) |
                  (va & keep_mask);
        done = 1'b1;
      end else begin
        r.fault = 1'b1;
        r.paddr = '0;
        done = 1'b1;
      end
    end
    return r;
  endfunction

  // Half are next-table descriptors, most of them inside the store, so walks go deep.
  function automatic logic [DESC_W-1:0] random_descriptor();
    logic [DESC_W-1:0] d;
    int                pick;
    d = {$urandom(), $urandom()};
    pick = $urandom_range(0, 15);
    if (pick < 8) begin
      d[1:0] = DTYPE_TABLE;
      if (pick != 0) begin
        d[ADDR_W-1:GRANULE_W] = {33'd0, 3'($urandom_range(0, 7))};
      end
    end else if (pick < 12) begin
      d[1:0] = DTYPE_BLOCK;
    end else if (pick < 14) begin
      d[1:0] = DTYPE_INVALID0;
    end else begin
      d[1:0] = DTYPE_INVALID2;
    end
    return d;
  endfunction

  // Random address; a third of them share the upper levels with the previous one.
  function automatic logic [ADDR_W-1:0] random_va();
    logic [ADDR_W-1:0] va;
    va = ADDR_W'({$urandom(), $urandom()});
    if ($urandom_range(0, 2) == 0) begin
      va[ADDR_W-1:21] = last_va[ADDR_W-1:21];
    end
    return va;
  endfunction

  function automatic logic [ADDR_W-1:0] random_root_in_store();
    return {33'd0, 3'($urandom_range(0, 7)), 12'($urandom())};
  endfunction

  // Offers one transaction, with an occasional idle burst first, and waits for acceptance.
  task automatic send_item(input logic kind, input logic [WIDX_W-1:0] widx,
                           input logic [DESC_W-1:0] desc, input logic [ADDR_W-1:0] va,
                           input translation_t want);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push          <= 1'b1;
    in_kind       <= kind;
    in_word_index <= widx;
    in_descriptor <= desc;
    in_vaddr      <= va;
    @(posedge clk);
    while (full) @(posedge clk);
    if (kind == KIND_TRANSLATE) begin
      pending_translations.push_back(want);
    end
    items_sent++;
  endtask

  task automatic write_descriptor(input logic [WIDX_W-1:0] widx, input logic [DESC_W-1:0] desc);
    desc_mirror[widx] = desc;
    desc_written[widx] = 1'b1;
    send_item(KIND_WRITE, widx, desc, ADDR_W'({$urandom(), $urandom()}), '0);
  endtask

  // Fills in any never-written descriptor on the path before sending the translation.
  task automatic translate(input logic [ADDR_W-1:0] va);
    translation_t want;
    int           missing;
    want = walk_tables(va, missing);
    while (missing >= 0) begin
      write_descriptor(WIDX_W'(missing), random_descriptor());
      want = walk_tables(va, missing);
    end
    last_va = va;
    send_item(KIND_TRANSLATE, WIDX_W'($urandom()), {$urandom(), $urandom()}, va, want);
  endtask

  task automatic random_item();
    if ($urandom_range(0, 9) == 0) begin
      write_descriptor(WIDX_W'($urandom()), random_descriptor());
    end else begin
      translate(random_va());
    end
  endtask

  // Stops sending and waits until every result has come and the back end has settled.
  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (pending_translations.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [ADDR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    root_base = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Hand-built chains from the reset root: pages, blocks at every level, both invalid
  // types, a table beyond the store, a block type at the page level and the top address.
  task automatic test_directed_walks();
    write_descriptor(12'd0, 64'h0000_0000_0000_1003);
    write_descriptor(12'd512, 64'h0000_0000_0000_2003);
    write_descriptor(12'd1024, 64'h0000_0000_0000_3003);
    write_descriptor(12'd1536, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(48'h0000_0000_0000);
    translate(48'h0000_0000_0FFF);
    write_descriptor(12'd1025, 64'h0000_00AB_CDE0_0001);
    translate(48'h0000_003F_FFFF);
    write_descriptor(12'd513, 64'hF0F0_5A5A_5A5A_5A5D);
    translate(48'h0000_7FFF_FFFF);
    write_descriptor(12'd1, 64'h1234_FFFF_FFFF_FFF1);
    translate(48'h00FF_FFFF_FFFF);
    write_descriptor(12'd1537, 64'hFFFF_FFFF_FFFF_FFFC);
    translate(48'h0000_0000_1000);
    write_descriptor(12'd514, 64'h0000_0000_5000_0002);
    translate(48'h0000_8000_0000);
    write_descriptor(12'd2, 64'h0000_8000_0000_0003);
    translate(48'h0100_0000_0000);
    write_descriptor(12'd1538, 64'h0000_8765_4321_0001);
    translate(48'h0000_0000_2ABC);
    write_descriptor(12'd511, 64'h0000_0000_0000_4003);
    write_descriptor(12'd2559, 64'h0000_0000_0000_5003);
    write_descriptor(12'd3071, 64'h0000_0000_0000_6003);
    write_descriptor(12'd3583, 64'h0000_C3C3_C3C3_C003);
    translate(48'hFFFF_FFFF_FFFF);
  endtask

  // Sweeps the root register through its extremes, 48'h7FFF and random values.
  task automatic test_root_settings();
    logic [ADDR_W-1:0] roots [5];
    roots[0] = 48'hFFFF_FFFF_FFFF;
    roots[1] = 48'h0000_0000_7FFF;
    roots[2] = ADDR_W'({$urandom(), $urandom()});
    roots[3] = random_root_in_store();
    roots[4] = 48'h0000_0000_0000;
    foreach (roots[i]) begin
      wait_idle();
      write_root(roots[i]);
      repeat (30) random_item();
    end
  endtask

  // The receiver holds off while translations keep coming, so the input side stalls.
  task automatic test_full_queue();
    wait_idle();
    write_root(random_root_in_store());
    hold_off_request = 1'b1;
    repeat (40) translate(random_va());
    wait_idle();
  endtask

  // Bulk random traffic, with a new root between phases.
  task automatic test_random_traffic();
    int phase_count;
    phase_count = 0;
    while (items_sent < ITEM_TARGET - FINAL_ITEMS) begin
      random_item();
      phase_count++;
      if (phase_count == PHASE_ITEMS) begin
        phase_count = 0;
        wait_idle();
        write_root(random_root_in_store());
      end
    end
  endtask

  // Back-to-back traffic with no random idle bursts on either side.
  task automatic test_no_idling();
    idling_on = 1'b0;
    repeat (FINAL_ITEMS) random_item();
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_walks();
    test_root_settings();
    test_full_queue();
    test_random_traffic();
    test_no_idling();
    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ptw_pkg.sv
rtl/ptw_ram.sv
rtl/ptw_front.sv
rtl/ptw_back.sv
rtl/page_table_walker_top.sv
test/testbench.sv
